FILE: hdl/mpow_pkg.sv
// Shared types and constants for the modular power unit.
// Used by mpow_ctrl, mpow_dp and modular_power_unit; depends on nothing.
package mpow_pkg;

  localparam int unsigned MOD_W  = 31;
  localparam int unsigned IN_W   = 63;
  localparam int unsigned PROD_W = 2 * MOD_W;
  localparam int unsigned CNT_W  = $clog2(IN_W);
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

  // Register index of the modulus on the configuration port.
  localparam logic REG_MODULUS = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;       // take a new request: start reducing the base, hold the exponent
    logic red_exp;   // start reducing the held exponent by modulus - 1
    logic red_prod;  // start reducing the product register by the modulus
    logic mul_en;    // load the product register
    logic mul_sq;    // product is b * b rather than acc * b
    logic wr_b;      // remainder to b
    logic wr_e;      // remainder to e
    logic wr_acc;    // remainder to acc
    logic e_shift;   // drop the lowest exponent bit
    logic acc_zero;  // force the result to zero
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic red_busy;
    logic e_zero;
    logic e_lsb;
    logic m_small;
  } stat_t;

endpackage

FILE: hdl/modular_power_unit.sv
// Modular power unit: base ** exponent mod modulus, right-to-left square-and-multiply.
// When the modulus is below two the result is forced to zero and done follows in the next cycle;
// otherwise the unit reduces both inputs, then for each reduced exponent bit (31 bits at most)
// multiplies for a set bit and squares, each product reduced by the one-bit-a-cycle remainder
// unit. One request at a time, the next taken the cycle after done; no stalls.
// Synchronous active-high reset returns the controller to idle and the modulus to 1000000007.
module modular_power_unit (
  input  logic                               clk,
  input  logic                               rst,
  // Request channel.
  input  logic                               start,
  output logic                               busy,
  input  logic [mpow_pkg::IN_W-1:0]          base_value,
  input  logic [mpow_pkg::IN_W-1:0]          exponent_value,
  // Result channel: valid for the single cycle in which done is high.
  output logic                               done,
  output logic [mpow_pkg::MOD_W-1:0]         power_result,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mpow_pkg::ADDR_W-1:0]        paddr,
  input  logic [mpow_pkg::DATA_W-1:0]        pwdata,
  output logic [mpow_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  mpow_pkg::cmd_t  cmd;
  mpow_pkg::stat_t stat;

  logic [mpow_pkg::MOD_W-1:0] modulus;
  logic                       reg_sel;
  logic                       cfg_wr;

  // Registers sit on 32-bit words; bit 2 of the address picks the word, and only
  // the first word exists. Writes to any other word are dropped.
  assign reg_sel = (paddr[2] == mpow_pkg::REG_MODULUS);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mpow_pkg::MODULUS_RESET;
    end else if (cfg_wr && reg_sel) begin
      modulus <= pwdata[mpow_pkg::MOD_W-1:0];
    end
  end

  // Reads of the missing word return zero.
  assign prdata = reg_sel ? {1'b0, modulus} : '0;

  // The controller sequences the reductions and the multiply steps; the datapath
  // holds all operands and reports when its remainder unit is free, whether the exponent
  // is zero, what its lowest bit is and whether the modulus is below two.
  mpow_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  mpow_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .modulus        (modulus),
    .base_value     (base_value),
    .exponent_value (exponent_value),
    .stat           (stat),
    .power_result   (power_result)
  );

`ifndef SYNTHESIS
  // A finished result is always reduced, apart from the zero given for a tiny modulus.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (power_result < modulus) || (power_result == '0))
    else $error("power_result not reduced by the modulus");

  // An accepted request keeps the unit busy on the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but unit not busy");

  // The unit only becomes busy because a request was taken.
  assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("unit became busy without a request");
`endif

endmodule

FILE: hdl/mpow_ctrl.sv
// Controller state machine for the modular power unit.
// Depends on mpow_pkg; drives mpow_dp through cmd_t and reads stat_t.
module mpow_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  mpow_pkg::stat_t stat,
  output mpow_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RB   = 4'd1;
  localparam logic [3:0] S_RE   = 4'd2;
  localparam logic [3:0] S_LOOP = 4'd3;
  localparam logic [3:0] S_MA   = 4'd4;
  localparam logic [3:0] S_WA   = 4'd5;
  localparam logic [3:0] S_MS   = 4'd6;
  localparam logic [3:0] S_WS   = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (stat.m_small) begin
            cmd.acc_zero = 1'b1;
            state_next   = S_DONE;
          end else begin
            cmd.cap    = 1'b1;
            state_next = S_RB;
          end
        end
      end
      S_RB: begin
        if (!stat.red_busy) begin
          cmd.wr_b    = 1'b1;
          cmd.red_exp = 1'b1;
          state_next  = S_RE;
        end
      end
      S_RE: begin
        if (!stat.red_busy) begin
          cmd.wr_e   = 1'b1;
          state_next = S_LOOP;
        end
      end
      S_LOOP: begin
        if (stat.e_zero) begin
          state_next = S_DONE;
        end else if (stat.e_lsb) begin
          cmd.mul_en = 1'b1;
          state_next = S_MA;
        end else begin
          cmd.mul_en = 1'b1;
          cmd.mul_sq = 1'b1;
          state_next = S_MS;
        end
      end
      S_MA: begin
        cmd.red_prod = 1'b1;
        state_next   = S_WA;
      end
      S_WA: begin
        if (!stat.red_busy) begin
          cmd.wr_acc = 1'b1;
          cmd.mul_en = 1'b1;
          cmd.mul_sq = 1'b1;
          state_next = S_MS;
        end
      end
      S_MS: begin
        cmd.red_prod = 1'b1;
        state_next   = S_WS;
      end
      S_WS: begin
        if (!stat.red_busy) begin
          cmd.wr_b    = 1'b1;
          cmd.e_shift = 1'b1;
          state_next  = S_LOOP;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

FILE: hdl/mpow_dp.sv
// Datapath of the modular power unit: operand registers, one 31 x 31 multiplier
// and a bit-serial restoring remainder unit shared by every reduction.
// Depends on mpow_pkg; commanded by mpow_ctrl.
module mpow_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  mpow_pkg::cmd_t                cmd,
  input  logic [mpow_pkg::MOD_W-1:0]    modulus,
  input  logic [mpow_pkg::IN_W-1:0]     base_value,
  input  logic [mpow_pkg::IN_W-1:0]     exponent_value,
  output mpow_pkg::stat_t               stat,
  output logic [mpow_pkg::MOD_W-1:0]    power_result
);

  logic [mpow_pkg::IN_W-1:0]   exp_hold;
  logic [mpow_pkg::MOD_W-1:0]  b;
  logic [mpow_pkg::MOD_W-1:0]  e;
  logic [mpow_pkg::MOD_W-1:0]  acc;
  logic [mpow_pkg::PROD_W-1:0] prod;
  logic [mpow_pkg::PROD_W-1:0] prod_next;
  logic [mpow_pkg::MOD_W-1:0]  mul_a;

  // Remainder unit.
  logic [mpow_pkg::IN_W-1:0]   sh;
  logic [mpow_pkg::MOD_W-1:0]  rem;
  logic [mpow_pkg::MOD_W-1:0]  rem_next;
  logic [mpow_pkg::MOD_W-1:0]  div;
  logic [mpow_pkg::CNT_W-1:0]  cnt;
  logic                        red_busy;
  logic [mpow_pkg::MOD_W:0]    trial;
  logic [mpow_pkg::MOD_W:0]    diff;

  assign mul_a     = cmd.mul_sq ? b : acc;
  assign prod_next = mul_a * b;

  // One quotient bit per cycle: bring in the next dividend bit, subtract if it fits.
  assign trial    = {rem, sh[mpow_pkg::IN_W-1]};
  assign diff     = trial - {1'b0, div};
  assign rem_next = (trial >= {1'b0, div}) ? diff[mpow_pkg::MOD_W-1:0]
                                           : trial[mpow_pkg::MOD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      red_busy <= 1'b0;
    end else if (cmd.cap || cmd.red_exp || cmd.red_prod) begin
      red_busy <= 1'b1;
    end else if (red_busy && (cnt == '0)) begin
      red_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      sh       <= base_value;
      exp_hold <= exponent_value;
      div      <= modulus;
      rem      <= '0;
      cnt      <= mpow_pkg::CNT_W'(mpow_pkg::IN_W - 1);
    end else if (cmd.red_exp) begin
      sh  <= exp_hold;
      div <= modulus - mpow_pkg::MOD_W'(1);
      rem <= '0;
      cnt <= mpow_pkg::CNT_W'(mpow_pkg::IN_W - 1);
    end else if (cmd.red_prod) begin
      sh  <= {1'b0, prod};
      div <= modulus;
      rem <= '0;
      cnt <= mpow_pkg::CNT_W'(mpow_pkg::IN_W - 1);
    end else if (red_busy) begin
      sh  <= {sh[mpow_pkg::IN_W-2:0], 1'b0};
      rem <= rem_next;
      cnt <= cnt - mpow_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= prod_next;
    end
    if (cmd.wr_b) begin
      b <= rem;
    end
    if (cmd.wr_e) begin
      e <= rem;
    end else if (cmd.e_shift) begin
      e <= {1'b0, e[mpow_pkg::MOD_W-1:1]};
    end
    if (cmd.acc_zero) begin
      acc <= '0;
    end else if (cmd.cap) begin
      acc <= mpow_pkg::MOD_W'(1);
    end else if (cmd.wr_acc) begin
      acc <= rem;
    end
  end

  assign stat.red_busy = red_busy;
  assign stat.e_zero   = (e == '0);
  assign stat.e_lsb    = e[0];
  assign stat.m_small  = (modulus < mpow_pkg::MOD_W'(2));
  assign power_result  = acc;

endmodule
